// ===== rtl/core/chat_line_tokenizer_top_defines.svh =====
// ---------------------------------------------------------------------------
// chat_line_tokenizer_top_defines
// Assertion macros used by the chat line tokenizer top module.
// ---------------------------------------------------------------------------
`ifndef CHAT_LINE_TOKENIZER_TOP_DEFINES_SVH
`define CHAT_LINE_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clt assertion failed");

// next-cycle implication, disabled during reset
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clt assertion failed");

`endif

// ===== rtl/core/clt_pkg.sv =====
// ---------------------------------------------------------------------------
// clt_pkg
// Types and constants of the chat line tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LEAD   = 3'd1,
    PH_PREFIX = 3'd2,
    PH_GAPCMD = 3'd3,
    PH_CMD    = 3'd4,
    PH_GAPPAR = 3'd5,
    PH_MIDDLE = 3'd6,
    PH_TRAIL  = 3'd7
  } phase_t;

  localparam logic [2:0] KIND_SEP    = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_CMD    = 3'd2;
  localparam logic [2:0] KIND_MIDDLE = 3'd3;
  localparam logic [2:0] KIND_TRAIL  = 3'd4;

  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] COLON_CH = 8'h3A;

  localparam logic [2:0] CMD_LEN_MAX    = 3'd4;
  localparam logic [2:0] CMD_LEN_DIGITS = 3'd3;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] params_seen;
    logic [2:0] cmd_len;
    logic       only_letters;
    logic       only_digits;
    logic       line_failed;
  } clt_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] pnum;
    logic       begins;
    logic       valid;
  } clt_tag_t;

  localparam clt_state_t STATE_RESET = '{
    phase:        PH_START,
    params_seen:  4'd0,
    cmd_len:      3'd0,
    only_letters: 1'b1,
    only_digits:  1'b1,
    line_failed:  1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/core/clt_step.sv =====
// ---------------------------------------------------------------------------
// clt_step
// Per-byte tagging and next-state logic of the line tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

module clt_step import clt_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  wire logic [7:0] line_byte,
  input  wire logic       last,
  input  wire clt_state_t state_cur,
  output clt_state_t      state_nxt,
  output clt_tag_t        tag
);

  logic       sp;
  logic       colon;
  logic       alpha;
  logic       digit;
  logic       room;
  logic       fail;
  logic       cmd_ok_cur;
  logic       cmd_ok_nxt;
  clt_state_t s;
  logic [2:0] len_inc;

  assign sp    = (line_byte == SPACE_CH);
  assign colon = (line_byte == COLON_CH);
  assign alpha = ((line_byte >= 8'h41) && (line_byte <= 8'h5A)) ||
                 ((line_byte >= 8'h61) && (line_byte <= 8'h7A));
  assign digit = (line_byte >= 8'h30) && (line_byte <= 8'h39);
  assign room  = (state_cur.params_seen < 4'(MAX_PARAMS));
  assign len_inc = (state_cur.cmd_len < CMD_LEN_MAX) ? state_cur.cmd_len + 3'd1
                                                     : state_cur.cmd_len;
  assign cmd_ok_cur = state_cur.only_letters ||
                      (state_cur.only_digits && (state_cur.cmd_len == CMD_LEN_DIGITS));

  always_comb begin
    s          = state_cur;
    tag.kind   = KIND_SEP;
    tag.pnum   = 4'd0;
    tag.begins = 1'b0;
    tag.valid  = 1'b0;
    unique case (state_cur.phase)
      PH_START: begin
        if (colon) begin
          tag.kind   = KIND_PREFIX;
          tag.begins = 1'b1;
          s.cmd_len  = 3'd0;
          s.phase    = PH_PREFIX;
        end else if (sp) begin
          s.phase = PH_LEAD;
        end else begin
          tag.kind       = KIND_CMD;
          tag.begins     = 1'b1;
          s.cmd_len      = 3'd1;
          s.only_letters = alpha;
          s.only_digits  = digit;
          s.phase        = PH_CMD;
        end
      end
      PH_LEAD, PH_GAPCMD: begin
        if (!sp) begin
          tag.kind       = KIND_CMD;
          tag.begins     = 1'b1;
          s.cmd_len      = 3'd1;
          s.only_letters = alpha;
          s.only_digits  = digit;
          s.phase        = PH_CMD;
        end
      end
      PH_PREFIX: begin
        if (sp) begin
          if (state_cur.cmd_len == 3'd0) begin
            s.line_failed = 1'b1;
          end
          s.cmd_len = 3'd0;
          s.phase   = PH_GAPCMD;
        end else begin
          tag.kind  = KIND_PREFIX;
          s.cmd_len = len_inc;
        end
      end
      PH_CMD: begin
        if (sp) begin
          if (!cmd_ok_cur) begin
            s.line_failed = 1'b1;
          end
          s.phase = PH_GAPPAR;
        end else begin
          tag.kind       = KIND_CMD;
          s.cmd_len      = len_inc;
          s.only_letters = state_cur.only_letters & alpha;
          s.only_digits  = state_cur.only_digits & digit;
        end
      end
      PH_GAPPAR: begin
        if (!sp && room) begin
          tag.pnum   = state_cur.params_seen;
          tag.begins = 1'b1;
          if (colon) begin
            tag.kind = KIND_TRAIL;
            s.phase  = PH_TRAIL;
          end else begin
            tag.kind = KIND_MIDDLE;
            s.phase  = PH_MIDDLE;
          end
        end
      end
      PH_MIDDLE: begin
        if (sp) begin
          s.params_seen = state_cur.params_seen + 4'd1;
          s.phase       = PH_GAPPAR;
        end else begin
          tag.kind = KIND_MIDDLE;
          tag.pnum = state_cur.params_seen;
        end
      end
      PH_TRAIL: begin
        tag.kind = KIND_TRAIL;
        tag.pnum = state_cur.params_seen;
      end
      default: begin
        s = state_cur;
      end
    endcase

    cmd_ok_nxt = s.only_letters || (s.only_digits && (s.cmd_len == CMD_LEN_DIGITS));
    fail = s.line_failed ||
           ((s.phase == PH_PREFIX) && (s.cmd_len == 3'd0)) ||
           (s.phase == PH_LEAD) ||
           ((s.phase == PH_CMD) && !cmd_ok_nxt);
    if (last) begin
      tag.valid = !fail;
      state_nxt = STATE_RESET;
    end else begin
      state_nxt = s;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/chat_line_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// chat_line_tokenizer_top
// Streaming tokenizer for one chat-protocol line, one byte per transfer.
// The result is registered (one result register) and is valid in the cycle after the input transfer.
// Throughput: 1 byte per cycle while out_tready keeps the result register draining.
// in_tready stays high while the result register is empty or being drained.
// Reset: synchronous, active low; clears the line state and the result valid.
// ---------------------------------------------------------------------------
`default_nettype none
`include "chat_line_tokenizer_top_defines.svh"

module chat_line_tokenizer_top import clt_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // [7:0] line_byte
  input  wire logic        in_tlast,  // end_of_line
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // [7:0] out_byte, [11:8] param_number,
                                      // [12] token_begins, [13] line_valid, [15:14] 0
  output logic [2:0]       out_tuser, // [2:0] token_kind
  output logic             out_tlast  // line_done
);

  clt_state_t  state_r;
  clt_state_t  state_nxt;
  clt_tag_t    tag;
  logic        in_xfer;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [7:0]  byte_r;
  clt_tag_t    tag_r;
  logic        last_r;

  clt_step #(.MAX_PARAMS(MAX_PARAMS)) u_step (
    .line_byte (in_tdata),
    .last      (in_tlast),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .tag       (tag)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_tdata;
      tag_r  <= tag;
      last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, tag_r.valid, tag_r.begins, tag_r.pnum, byte_r};
  assign out_tuser  = tag_r.kind;
  assign out_tlast  = last_r;

  `CLT_ASSERT_NEXT(a_reset_after_last, clk, rst_n, in_xfer && in_tlast,
    state_r == STATE_RESET)
  `CLT_ASSERT_NOW(a_valid_only_on_last, clk, rst_n, out_tvalid && !out_tlast,
    !out_tdata[13])
  `CLT_ASSERT_NOW(a_pnum_only_params, clk, rst_n,
    out_tvalid && (out_tuser != KIND_MIDDLE) && (out_tuser != KIND_TRAIL),
    out_tdata[11:8] == 4'd0)
  `CLT_ASSERT_NOW(a_params_bounded, clk, rst_n, 1'b1,
    state_r.params_seen <= 4'(MAX_PARAMS))

endmodule

`default_nettype wire
